@@ rtl/core/soft_knee_peak_compressor_top_defines.svh @@
// Assertion macros shared by the compressor's checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SOFT_KNEE_PEAK_COMPRESSOR_TOP_DEFINES_SVH
`define SOFT_KNEE_PEAK_COMPRESSOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/skpc_pkg.sv @@
// Shared types, constants and tables of the soft-knee peak compressor.
// Used by every module of the block; depends on nothing.
package skpc_pkg;

	// Sample width and derived widths.
	localparam int SAMPLE_BITS = 24;
	localparam int NORM_W      = 32;
	localparam int SHIFT_W     = $clog2(SAMPLE_BITS);
	localparam int NEG_W       = SHIFT_W + 16;
	localparam int OUT_PROD_W  = SAMPLE_BITS + 31;
	localparam int YM_W        = OUT_PROD_W - 29;

	// Iteration counts of the sequenced loops.
	localparam int SQ_STEPS   = 16;
	localparam int DIV_Q_BITS = 17;
	localparam int EXP_STEPS  = 16;

	// Fixed-point constants.
	localparam logic [15:0] FLOOR_DB_Q8         = 16'd24576;
	localparam logic [31:0] DB_PER_OCTAVE_Q16   = 32'd394566;
	localparam logic [31:0] LOG2_10_OVER_20_Q16 = 32'd10885;
	localparam logic [30:0] ONE_Q30             = 31'h4000_0000;
	localparam logic [14:0] UNITY_RATIO         = 15'd256;

	// Register reset values.
	localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
	localparam logic [14:0]        RATIO_RST     = 15'd1024;
	localparam logic [13:0]        KNEE_RST      = 14'd1536;
	localparam logic [15:0]        ATTACK_RST    = 16'd65000;
	localparam logic [15:0]        RELEASE_RST   = 16'd65500;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_RATIO     = 3'd1,
		REG_KNEE      = 3'd2,
		REG_ATTACK    = 3'd3,
		REG_RELEASE   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] threshold_db;
		logic [14:0]        ratio;
		logic [13:0]        knee_width_db;
		logic [15:0]        attack_coef;
		logic [15:0]        release_coef;
	} cfg_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_NORM,
		OP_SQ,
		OP_LVL_MUL,
		OP_LVL,
		OP_REGION,
		OP_A_MUL,
		OP_A_LOAD,
		OP_K_MUL1,
		OP_K_MUL2,
		OP_K_MUL3,
		OP_K_LOAD,
		OP_DIV,
		OP_CHG,
		OP_SM1,
		OP_SM2,
		OP_SM3,
		OP_EXP_MUL,
		OP_EXP_INIT,
		OP_EXP_STEP,
		OP_EXP_SHIFT,
		OP_OUT_MUL,
		OP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		RGN_NONE,
		RGN_KNEE,
		RGN_ABOVE
	} region_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic    mag_zero;
		logic    y_msb;
		region_t region;
	} dp_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ,
		ST_LVL_MUL,
		ST_LVL,
		ST_REGION,
		ST_A_MUL,
		ST_A_LOAD,
		ST_K_MUL1,
		ST_K_MUL2,
		ST_K_MUL3,
		ST_K_LOAD,
		ST_DIV,
		ST_CHG,
		ST_SM1,
		ST_SM2,
		ST_SM3,
		ST_EXP_MUL,
		ST_EXP_INIT,
		ST_EXP_STEP,
		ST_EXP_SHIFT,
		ST_OUT_MUL,
		ST_OUT
	} ctrl_state_t;

	// 2^-(2^-(k+1)) in Q.30 for k = 0..15.
	function automatic logic [29:0] exp2_neg(input logic [3:0] k);
		logic [29:0] v;
		unique case (k)
			4'd0:  v = 30'd759250125;
			4'd1:  v = 30'd902905651;
			4'd2:  v = 30'd984625594;
			4'd3:  v = 30'd1028218693;
			4'd4:  v = 30'd1050733751;
			4'd5:  v = 30'd1062175490;
			4'd6:  v = 30'd1067943000;
			4'd7:  v = 30'd1070838487;
			4'd8:  v = 30'd1072289173;
			4'd9:  v = 30'd1073015252;
			4'd10: v = 30'd1073378476;
			4'd11: v = 30'd1073560135;
			4'd12: v = 30'd1073650975;
			4'd13: v = 30'd1073696399;
			4'd14: v = 30'd1073719111;
			4'd15: v = 30'd1073730467;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/skpc_regs.sv @@
// Configuration register file of the compressor.
// Depends on skpc_pkg for the register indexes and the cfg_t struct.
module skpc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output skpc_pkg::cfg_t      cfg
);

	skpc_pkg::cfg_t cfg_q;

	// Writes are always taken; indexes beyond the list are dropped.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register update on each write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db  <= skpc_pkg::THRESHOLD_RST;
			cfg_q.ratio         <= skpc_pkg::RATIO_RST;
			cfg_q.knee_width_db <= skpc_pkg::KNEE_RST;
			cfg_q.attack_coef   <= skpc_pkg::ATTACK_RST;
			cfg_q.release_coef  <= skpc_pkg::RELEASE_RST;
		end else if (cfg_valid) begin
			case (skpc_pkg::reg_idx_t'(cfg_index))
				skpc_pkg::REG_THRESHOLD: cfg_q.threshold_db  <= cfg_data;
				skpc_pkg::REG_RATIO:     cfg_q.ratio         <= cfg_data[14:0];
				skpc_pkg::REG_KNEE:      cfg_q.knee_width_db <= cfg_data[13:0];
				skpc_pkg::REG_ATTACK:    cfg_q.attack_coef   <= cfg_data;
				skpc_pkg::REG_RELEASE:   cfg_q.release_coef  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/skpc_dp.sv @@
// Datapath of the compressor: level detector, gain computer, divider,
// smoother, exponent unit and output scaling around one shared multiplier.
// Depends on skpc_pkg; driven by commands from skpc_ctrl.
module skpc_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  skpc_pkg::dp_cmd_t                       cmd,
	input  skpc_pkg::cfg_t                          cfg,
	input  logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_in,
	output skpc_pkg::dp_status_t                    status,
	output logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic signed [15:0]                      gain_db
);

	localparam int SB = skpc_pkg::SAMPLE_BITS;
	localparam int OUT_PROD_W_P1 = skpc_pkg::OUT_PROD_W + 1;

	// Working registers.
	logic                          sign_q;
	logic [SB-1:0]                 mag_q;
	logic [skpc_pkg::NORM_W-1:0]   y_q;
	logic [skpc_pkg::SHIFT_W-1:0]  shift_q;
	logic [15:0]                   frac_q;
	logic [63:0]                   prod_q;
	logic signed [15:0]            lvl_q;
	logic signed [17:0]            d_q;
	logic [14:0]                   v_q;
	logic [14:0]                   rm_q;
	logic [14:0]                   rr_q;
	skpc_pkg::region_t             region_q;
	logic [45:0]                   num_q;
	logic [32:0]                   rem_q;
	logic [32:0]                   den_q;
	logic [16:0]                   lo_q;
	logic signed [15:0]            chg_q;
	logic [15:0]                   a_q;
	logic [32:0]                   acc_q;
	logic signed [15:0]            gain_q;
	logic [16:0]                   gmag_q;
	logic [20:0]                   e_q;
	logic [30:0]                   lin_q;
	logic signed [SB-1:0]          sample_out_q;
	logic signed [15:0]            gain_db_q;

	// Combinational helpers.
	logic [SB-1:0]                 mag_in;
	logic [skpc_pkg::NEG_W-1:0]    neg_c;
	logic [14:0]                   r_eff;
	logic signed [17:0]            d_c;
	logic signed [18:0]            two_d;
	logic signed [18:0]            w_s;
	logic [18:0]                   v_c;
	skpc_pkg::region_t             region_c;
	logic [31:0]                   mul_a;
	logic [31:0]                   mul_b;
	logic [63:0]                   mul_p;
	logic [15:0]                   a_sel;
	logic [16:0]                   a_inv;
	logic [15:0]                   neg_chg;
	logic [15:0]                   neg_gain;
	logic [40:0]                   lvl_sum;
	logic [16:0]                   lvl_mag;
	logic [45:0]                   num_a;
	logic [45:0]                   num_k;
	logic [33:0]                   div_t;
	logic                          div_ge;
	logic [33:0]                   sm_sum;
	logic [17:0]                   sm_mag;
	logic [16:0]                   sm_mag_c;
	logic [29:0]                   e_sum;
	logic [15:0]                   e_frac;
	logic [4:0]                    e_ip;
	logic [60:0]                   exp_sum;
	logic [OUT_PROD_W_P1-1:0]      ym_sum;
	logic [skpc_pkg::YM_W-1:0]     ym;

	// Magnitude of the incoming sample and the octave count minus fraction.
	assign mag_in = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
	assign neg_c  = {shift_q, 16'd0} - {{skpc_pkg::SHIFT_W{1'b0}}, frac_q};

	// Gain computer region from the level and the threshold.
	assign r_eff    = (cfg.ratio < skpc_pkg::UNITY_RATIO) ? skpc_pkg::UNITY_RATIO : cfg.ratio;
	assign d_c      = {{2{lvl_q[15]}}, lvl_q} - {{2{cfg.threshold_db[15]}}, cfg.threshold_db};
	assign two_d    = {d_c, 1'b0};
	assign w_s      = $signed({5'd0, cfg.knee_width_db});
	assign v_c      = 19'(two_d + w_s);

	always_comb begin
		if (two_d > w_s) begin
			region_c = skpc_pkg::RGN_ABOVE;
		end else if (two_d > -w_s) begin
			region_c = skpc_pkg::RGN_KNEE;
		end else begin
			region_c = skpc_pkg::RGN_NONE;
		end
	end

	// Smoother coefficient: attack when the change goes below the held gain.
	assign a_sel    = (chg_q < gain_q) ? cfg.attack_coef : cfg.release_coef;
	assign a_inv    = 17'h1_0000 - {1'b0, a_sel};
	assign neg_chg  = 16'(-chg_q);
	assign neg_gain = 16'(-gain_q);

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			skpc_pkg::OP_SQ: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			skpc_pkg::OP_LVL_MUL: begin
				mul_a = 32'(neg_c);
				mul_b = skpc_pkg::DB_PER_OCTAVE_Q16;
			end
			skpc_pkg::OP_A_MUL: begin
				mul_a = 32'(d_q[16:0]);
				mul_b = 32'(rm_q);
			end
			skpc_pkg::OP_K_MUL1: begin
				mul_a = 32'(rm_q);
				mul_b = 32'(v_q);
			end
			skpc_pkg::OP_K_MUL2: begin
				mul_a = 32'(prod_q[29:0]);
				mul_b = 32'(v_q);
			end
			skpc_pkg::OP_K_MUL3: begin
				mul_a = 32'(rr_q);
				mul_b = 32'(cfg.knee_width_db);
			end
			skpc_pkg::OP_SM1: begin
				mul_a = 32'(a_inv);
				mul_b = 32'(neg_chg);
			end
			skpc_pkg::OP_SM2: begin
				mul_a = 32'(a_q);
				mul_b = 32'(neg_gain);
			end
			skpc_pkg::OP_EXP_MUL: begin
				mul_a = 32'(gmag_q);
				mul_b = skpc_pkg::LOG2_10_OVER_20_Q16;
			end
			skpc_pkg::OP_EXP_STEP: begin
				mul_a = 32'(lin_q);
				mul_b = 32'(skpc_pkg::exp2_neg(cmd.idx));
			end
			skpc_pkg::OP_OUT_MUL: begin
				mul_a = 32'(mag_q);
				mul_b = 32'(lin_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Level rounding, divider step, smoother rounding, exponent and output rounding.
	assign lvl_sum  = prod_q[40:0] + 41'h80_0000;
	assign lvl_mag  = lvl_sum[40:24];
	assign num_a    = {13'd0, prod_q[32:0]} + {32'd0, rr_q[14:1]};
	assign num_k    = num_q + {15'd0, prod_q[28:0], 2'b00};
	assign div_t    = {rem_q, lo_q[16]};
	assign div_ge   = div_t >= {1'b0, den_q};
	assign sm_sum   = {1'b0, acc_q} + {1'b0, prod_q[32:0]} + 34'd32768;
	assign sm_mag   = sm_sum[33:16];
	assign sm_mag_c = (sm_mag > 18'd32768) ? 17'd32768 : sm_mag[16:0];
	assign e_sum    = {1'b0, prod_q[28:0]} + 30'd128;
	assign e_frac   = e_q[15:0];
	assign e_ip     = e_q[20:16];
	assign exp_sum  = mul_p[60:0] + 61'h2000_0000;
	assign ym_sum   = {1'b0, prod_q[skpc_pkg::OUT_PROD_W-1:0]} + OUT_PROD_W_P1'(32'h2000_0000);
	assign ym       = ym_sum[skpc_pkg::OUT_PROD_W:30];

	// Smoothed gain is the only state that survives between samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'sd0;
		end else if (cmd.op == skpc_pkg::OP_SM3) begin
			gain_q <= 16'(18'd0 - {1'b0, sm_mag_c});
		end
	end

	// Working registers, written by the operation of the cycle.
	always_ff @(posedge clk) begin
		case (cmd.op)
			skpc_pkg::OP_LOAD: begin
				sign_q  <= sample_in[SB-1];
				mag_q   <= mag_in;
				y_q     <= skpc_pkg::NORM_W'(mag_in) << (skpc_pkg::NORM_W - SB);
				shift_q <= '0;
				frac_q  <= '0;
			end
			skpc_pkg::OP_NORM: begin
				y_q     <= {y_q[skpc_pkg::NORM_W-2:0], 1'b0};
				shift_q <= shift_q + 1'b1;
			end
			skpc_pkg::OP_SQ: begin
				if (mul_p[63]) begin
					y_q    <= mul_p[63:32];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					y_q    <= mul_p[62:31];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			skpc_pkg::OP_LVL_MUL: begin
				prod_q <= mul_p;
			end
			skpc_pkg::OP_LVL: begin
				if (mag_q == '0 || lvl_mag > 17'(skpc_pkg::FLOOR_DB_Q8)) begin
					lvl_q <= 16'(17'd0 - 17'(skpc_pkg::FLOOR_DB_Q8));
				end else begin
					lvl_q <= 16'(17'd0 - lvl_mag);
				end
			end
			skpc_pkg::OP_REGION: begin
				d_q      <= d_c;
				v_q      <= v_c[14:0];
				rm_q     <= r_eff - skpc_pkg::UNITY_RATIO;
				rr_q     <= r_eff;
				region_q <= region_c;
			end
			skpc_pkg::OP_A_MUL, skpc_pkg::OP_K_MUL1, skpc_pkg::OP_K_MUL2: begin
				prod_q <= mul_p;
			end
			skpc_pkg::OP_K_MUL3: begin
				num_q  <= prod_q[45:0];
				prod_q <= mul_p;
			end
			skpc_pkg::OP_A_LOAD: begin
				rem_q <= {4'd0, num_a[45:17]};
				lo_q  <= num_a[16:0];
				den_q <= {18'd0, rr_q};
			end
			skpc_pkg::OP_K_LOAD: begin
				rem_q <= {4'd0, num_k[45:17]};
				lo_q  <= num_k[16:0];
				den_q <= {1'b0, prod_q[28:0], 3'b000};
			end
			skpc_pkg::OP_DIV: begin
				rem_q <= div_ge ? 33'(div_t - {1'b0, den_q}) : div_t[32:0];
				lo_q  <= {lo_q[15:0], div_ge};
			end
			skpc_pkg::OP_CHG: begin
				chg_q <= (region_q == skpc_pkg::RGN_NONE) ? 16'sd0 : 16'(17'd0 - lo_q);
			end
			skpc_pkg::OP_SM1: begin
				a_q    <= a_sel;
				prod_q <= mul_p;
			end
			skpc_pkg::OP_SM2: begin
				acc_q  <= prod_q[32:0];
				prod_q <= mul_p;
			end
			skpc_pkg::OP_SM3: begin
				gmag_q <= sm_mag_c;
			end
			skpc_pkg::OP_EXP_MUL: begin
				prod_q <= mul_p;
			end
			skpc_pkg::OP_EXP_INIT: begin
				e_q   <= e_sum[28:8];
				lin_q <= skpc_pkg::ONE_Q30;
			end
			skpc_pkg::OP_EXP_STEP: begin
				if (e_frac[~cmd.idx]) begin
					lin_q <= exp_sum[60:30];
				end
			end
			skpc_pkg::OP_EXP_SHIFT: begin
				lin_q <= (e_ip == 5'd31) ? 31'd0 : (lin_q >> e_ip);
			end
			skpc_pkg::OP_OUT_MUL: begin
				prod_q <= mul_p;
			end
			skpc_pkg::OP_OUT: begin
				gain_db_q <= gain_q;
				if (!sign_q) begin
					if (ym > skpc_pkg::YM_W'({(SB-1){1'b1}})) begin
						sample_out_q <= {1'b0, {(SB-1){1'b1}}};
					end else begin
						sample_out_q <= ym[SB-1:0];
					end
				end else begin
					if (ym > (skpc_pkg::YM_W'(1) << (SB-1))) begin
						sample_out_q <= {1'b1, {(SB-1){1'b0}}};
					end else begin
						sample_out_q <= SB'(~ym[SB-1:0] + SB'(1));
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller.
	assign status.mag_zero = (mag_q == '0);
	assign status.y_msb    = y_q[skpc_pkg::NORM_W-1];
	assign status.region   = region_c;

	assign sample_out = sample_out_q;
	assign gain_db    = gain_db_q;

endmodule

@@ rtl/core/skpc_ctrl.sv @@
// Controller of the compressor: sequences the datapath per sample and owns
// the handshakes of both channels. Depends on skpc_pkg.
module skpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  skpc_pkg::dp_status_t status,
	output skpc_pkg::dp_cmd_t    cmd
);

	skpc_pkg::ctrl_state_t state_q;
	skpc_pkg::ctrl_state_t state_d;
	logic [4:0]            step_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  out_load;

	// The output register can take a result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skpc_pkg::ST_IDLE: if (in_valid) state_d = skpc_pkg::ST_NORM;
			skpc_pkg::ST_NORM: begin
				if (status.mag_zero) begin
					state_d = skpc_pkg::ST_LVL;
				end else if (status.y_msb) begin
					state_d = skpc_pkg::ST_SQ;
				end
			end
			skpc_pkg::ST_SQ: begin
				if (step_q == 5'(skpc_pkg::SQ_STEPS - 1)) state_d = skpc_pkg::ST_LVL_MUL;
			end
			skpc_pkg::ST_LVL_MUL: state_d = skpc_pkg::ST_LVL;
			skpc_pkg::ST_LVL:     state_d = skpc_pkg::ST_REGION;
			skpc_pkg::ST_REGION: begin
				unique case (status.region)
					skpc_pkg::RGN_ABOVE: state_d = skpc_pkg::ST_A_MUL;
					skpc_pkg::RGN_KNEE:  state_d = skpc_pkg::ST_K_MUL1;
					default:             state_d = skpc_pkg::ST_CHG;
				endcase
			end
			skpc_pkg::ST_A_MUL:  state_d = skpc_pkg::ST_A_LOAD;
			skpc_pkg::ST_A_LOAD: state_d = skpc_pkg::ST_DIV;
			skpc_pkg::ST_K_MUL1: state_d = skpc_pkg::ST_K_MUL2;
			skpc_pkg::ST_K_MUL2: state_d = skpc_pkg::ST_K_MUL3;
			skpc_pkg::ST_K_MUL3: state_d = skpc_pkg::ST_K_LOAD;
			skpc_pkg::ST_K_LOAD: state_d = skpc_pkg::ST_DIV;
			skpc_pkg::ST_DIV: begin
				if (step_q == 5'(skpc_pkg::DIV_Q_BITS - 1)) state_d = skpc_pkg::ST_CHG;
			end
			skpc_pkg::ST_CHG:      state_d = skpc_pkg::ST_SM1;
			skpc_pkg::ST_SM1:      state_d = skpc_pkg::ST_SM2;
			skpc_pkg::ST_SM2:      state_d = skpc_pkg::ST_SM3;
			skpc_pkg::ST_SM3:      state_d = skpc_pkg::ST_EXP_MUL;
			skpc_pkg::ST_EXP_MUL:  state_d = skpc_pkg::ST_EXP_INIT;
			skpc_pkg::ST_EXP_INIT: state_d = skpc_pkg::ST_EXP_STEP;
			skpc_pkg::ST_EXP_STEP: begin
				if (step_q == 5'(skpc_pkg::EXP_STEPS - 1)) state_d = skpc_pkg::ST_EXP_SHIFT;
			end
			skpc_pkg::ST_EXP_SHIFT: state_d = skpc_pkg::ST_OUT_MUL;
			skpc_pkg::ST_OUT_MUL:   state_d = skpc_pkg::ST_OUT;
			skpc_pkg::ST_OUT:       if (out_free) state_d = skpc_pkg::ST_IDLE;
			default:                state_d = skpc_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath and handshake outputs.
	always_comb begin
		cmd.op   = skpc_pkg::OP_NONE;
		cmd.idx  = step_q[3:0];
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			skpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = skpc_pkg::OP_LOAD;
			end
			skpc_pkg::ST_NORM: begin
				if (!status.mag_zero && !status.y_msb) cmd.op = skpc_pkg::OP_NORM;
			end
			skpc_pkg::ST_SQ:        cmd.op = skpc_pkg::OP_SQ;
			skpc_pkg::ST_LVL_MUL:   cmd.op = skpc_pkg::OP_LVL_MUL;
			skpc_pkg::ST_LVL:       cmd.op = skpc_pkg::OP_LVL;
			skpc_pkg::ST_REGION:    cmd.op = skpc_pkg::OP_REGION;
			skpc_pkg::ST_A_MUL:     cmd.op = skpc_pkg::OP_A_MUL;
			skpc_pkg::ST_A_LOAD:    cmd.op = skpc_pkg::OP_A_LOAD;
			skpc_pkg::ST_K_MUL1:    cmd.op = skpc_pkg::OP_K_MUL1;
			skpc_pkg::ST_K_MUL2:    cmd.op = skpc_pkg::OP_K_MUL2;
			skpc_pkg::ST_K_MUL3:    cmd.op = skpc_pkg::OP_K_MUL3;
			skpc_pkg::ST_K_LOAD:    cmd.op = skpc_pkg::OP_K_LOAD;
			skpc_pkg::ST_DIV:       cmd.op = skpc_pkg::OP_DIV;
			skpc_pkg::ST_CHG:       cmd.op = skpc_pkg::OP_CHG;
			skpc_pkg::ST_SM1:       cmd.op = skpc_pkg::OP_SM1;
			skpc_pkg::ST_SM2:       cmd.op = skpc_pkg::OP_SM2;
			skpc_pkg::ST_SM3:       cmd.op = skpc_pkg::OP_SM3;
			skpc_pkg::ST_EXP_MUL:   cmd.op = skpc_pkg::OP_EXP_MUL;
			skpc_pkg::ST_EXP_INIT:  cmd.op = skpc_pkg::OP_EXP_INIT;
			skpc_pkg::ST_EXP_STEP:  cmd.op = skpc_pkg::OP_EXP_STEP;
			skpc_pkg::ST_EXP_SHIFT: cmd.op = skpc_pkg::OP_EXP_SHIFT;
			skpc_pkg::ST_OUT_MUL:   cmd.op = skpc_pkg::OP_OUT_MUL;
			skpc_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.op   = skpc_pkg::OP_OUT;
					out_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// State, loop counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skpc_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == state_d) ? step_q + 1'b1 : 5'd0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/soft_knee_peak_compressor_top.sv @@
// Soft-knee peak compressor, one sample in and one sample out. Each transfer
// on the input is processed alone by a sequenced datapath around one shared
// 32x32 multiplier: the path from the input transfer to the result in the
// output register runs through the leading-zero shift (one bit per cycle),
// 16 squaring steps of the log, a 17-step restoring divider in the gain
// computer (skipped below the knee) and 16 steps of the exponent. A new
// sample is taken once the previous result is loaded into the output
// register, which may still wait for its consumer. Configuration writes
// are accepted in every cycle and belong to idle periods.
module soft_knee_peak_compressor_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic signed [15:0]                      gain_db,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [2:0]                              cfg_index,
	input  logic [15:0]                             cfg_data
);

	skpc_pkg::cfg_t       cfg;
	skpc_pkg::dp_cmd_t    cmd;
	skpc_pkg::dp_status_t status;

	// Configuration registers.
	skpc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer.
	skpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic.
	skpc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (sample_in),
		.status     (status),
		.sample_out (sample_out),
		.gain_db    (gain_db)
	);

endmodule

@@ rtl/core/skpc_checker.sv @@
// Port-level checks of the compressor, bound to the top level.
// Depends on skpc_pkg and the assertion macros header.
`include "soft_knee_peak_compressor_top_defines.svh"

module skpc_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic signed [15:0]                      gain_db
);

	// The gain change only ever attenuates.
	`SKPC_ASSERT_IMPL(a_gain_nonpos, out_valid, gain_db[15] || gain_db == 16'sd0, "gain above 0 dB")

	// One sample at a time: after an input transfer the block is busy.
	`SKPC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")

	// A stalled result holds.
	`SKPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(gain_db), "stalled result changed")

endmodule

bind soft_knee_peak_compressor_top skpc_checker u_skpc_checker (.*);

@@ dv/soft_knee_peak_compressor_checker.sv @@
// Checker of the soft-knee peak compressor: it follows the configuration, input and output
// transfers, predicts each result and compares it with the result that comes out.
// Depends on skpc_pkg for the sample width, register indexes and register reset values.
module soft_knee_peak_compressor_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [skpc_pkg::SAMPLE_BITS-1:0] sample_out,
	input  logic signed [15:0]                      gain_db,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [2:0]                              cfg_index,
	input  logic [15:0]                             cfg_data,
	output int                                      errors,
	output int                                      pending
);
	import skpc_pkg::*;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic signed [15:0]            gain;
	} result_t;

	localparam longint FLOOR_Q8 = 24576;
	localparam longint unsigned GAIN_ONE = 64'd1073741824;

	// Gain-reduction factors 2^-(2^-(k+1)), Q.30.
	localparam longint unsigned POW_TAB [16] = '{
		759250125, 902905651, 984625594, 1028218693,
		1050733751, 1062175490, 1067943000, 1070838487,
		1072289173, 1073015252, 1073378476, 1073560135,
		1073650975, 1073696399, 1073719111, 1073730467
	};

	longint thr_q8, ratio_q8, knee_q8, attack_q16, release_q16, gain_state;
	result_t expected_results [$];

	assign pending = expected_results.size();

	// Level in dB Q8.8 of a magnitude, floored at -96 dB.
	function automatic longint level_q8(longint unsigned mag);
		int msb;
		longint unsigned y, frac, neg, d;
		msb = 0;
		frac = 0;
		if (mag == 0) begin
			return -FLOOR_Q8;
		end
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) begin
				msb = i;
			end
		end
		y = mag << (31 - msb);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		neg = (longint'(SAMPLE_BITS - 1 - msb) << 16) - frac;
		d = (neg * 394566 + (64'd1 << 23)) >> 24;
		if (d > FLOOR_Q8) begin
			d = FLOOR_Q8;
		end
		return -longint'(d);
	endfunction

	// Static gain curve with the soft knee around the threshold.
	function automatic longint static_gain(longint lvl);
		longint r, w, d, c, v, den;
		r = (ratio_q8 < 256) ? 256 : ratio_q8;
		w = knee_q8;
		d = lvl - thr_q8;
		c = 0;
		if (2 * d > w) begin
			c = -((d * (r - 256) + r / 2) / r);
		end else if (2 * d > -w) begin
			v = 2 * d + w;
			den = 8 * r * w;
			c = -(((r - 256) * v * v + den / 2) / den);
		end
		if (c < -32768) begin
			c = -32768;
		end
		return c;
	endfunction

	// Linear gain 10^(g/20) in Q.30.
	function automatic longint unsigned linear_gain(longint g);
		longint unsigned e, ip, r;
		e = (longint'(-g) * 10885 + 128) >> 8;
		ip = e >> 16;
		r = GAIN_ONE;
		for (int k = 0; k < 16; k++) begin
			if (e[15 - k]) begin
				r = (r * POW_TAB[k] + (64'd1 << 29)) >> 30;
			end
		end
		return (ip >= 31) ? 0 : (r >> ip);
	endfunction

	// Predicts one result and advances the smoothed gain.
	function automatic result_t compress(logic signed [SAMPLE_BITS-1:0] smp);
		result_t res;
		longint s, chg, a, g, y, lim;
		longint unsigned mag, n, ym;
		s = smp;
		mag = (s < 0) ? -s : s;
		chg = static_gain(level_q8(mag));
		a = (chg < gain_state) ? attack_q16 : release_q16;
		n = longint'(65536 - a) * longint'(-chg) + a * longint'(-gain_state);
		g = -longint'((n + 32768) >> 16);
		if (g < -32768) begin
			g = -32768;
		end
		gain_state = g;
		ym = (mag * linear_gain(g) + (64'd1 << 29)) >> 30;
		y = (s < 0) ? -longint'(ym) : longint'(ym);
		lim = longint'(1) << (SAMPLE_BITS - 1);
		if (y > lim - 1) begin
			y = lim - 1;
		end
		if (y < -lim) begin
			y = -lim;
		end
		res.sample = y[SAMPLE_BITS-1:0];
		res.gain = g[15:0];
		return res;
	endfunction

	// Follow every transfer on the three channels.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			thr_q8 <= longint'(THRESHOLD_RST);
			ratio_q8 <= RATIO_RST;
			knee_q8 <= KNEE_RST;
			attack_q16 <= ATTACK_RST;
			release_q16 <= RELEASE_RST;
			gain_state = 0;
			expected_results.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q8 <= longint'($signed(cfg_data));
					REG_RATIO:     ratio_q8 <= cfg_data[14:0];
					REG_KNEE:      knee_q8 <= cfg_data[13:0];
					REG_ATTACK:    attack_q16 <= cfg_data;
					REG_RELEASE:   release_q16 <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(compress(sample_in));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (errors < 10) begin
						$display("unexpected result: sample_out %0d gain_db %0d",
							sample_out, gain_db);
					end
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.sample !== sample_out || want.gain !== gain_db) begin
						if (errors < 10) begin
							$display("mismatch: sample_out exp %0d got %0d, gain_db exp %0d got %0d",
								want.sample, sample_out, want.gain, gain_db);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

@@ dv/soft_knee_peak_compressor_top_tb.sv @@
// Testbench top of the soft-knee peak compressor: clock, reset, configuration and sample
// stimulus with random idling and receiver stalls, and the verdict. Depends on skpc_pkg, the block and the checker.
module soft_knee_peak_compressor_top_tb;
	import skpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 100;
	localparam logic [2:0] REG_SPARE = 3'd5;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in, sample_out;
	logic signed [15:0] gain_db;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int errors, pending;
	int idle_pct, stall_pct, quiet_cycles;

	soft_knee_peak_compressor_top dut (.*);

	soft_knee_peak_compressor_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL soft_knee_peak_compressor_top");
			$finish;
		end
	end

	// Offer one sample after a random idle gap and wait for its transfer.
	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Stop offering samples and wait until every result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [15:0] thr, logic [15:0] rat, logic [15:0] knee,
		logic [15:0] att, logic [15:0] rel);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_RATIO, rat);
		write_reg(REG_KNEE, knee);
		write_reg(REG_ATTACK, att);
		write_reg(REG_RELEASE, rel);
	endtask

	// Random sample with its magnitude spread over the whole dB range.
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		logic signed [SAMPLE_BITS-1:0] s;
		s = $urandom();
		return s >>> $urandom_range(0, SAMPLE_BITS - 1);
	endfunction

	initial begin
		logic signed [SAMPLE_BITS-1:0] burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		sample_in = '0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples under the reset settings: extremes, zero and small levels.
		send_sample(24'sd0);
		send_sample(24'sh7FFFFF);
		send_sample(-24'sh800000);
		send_sample(24'sh7FFFFF);
		send_sample(-24'sd1);
		send_sample(24'sd1);
		send_sample(24'sd1000);
		send_sample(24'sh400000);
		drain();

		// Hard knee, steepest ratio, no smoothing, lowest threshold.
		write_all(-16'sd24576, 16'd16384, 16'd0, 16'd0, 16'd0);
		send_sample(24'sh7FFFFF);
		send_sample(-24'sh800000);
		send_sample(24'sd0);
		send_sample(24'sd1);
		send_sample(24'sh123456);
		drain();

		// Widest knee, unity ratio, slowest smoothing, threshold at full scale.
		write_all(16'd0, 16'd256, 16'd12288, 16'd65535, 16'd65535);
		send_sample(24'sh7FFFFF);
		send_sample(-24'sh800000);
		send_sample(24'sh010000);
		drain();

		// Ratio of zero counts as unity; writes to spare indexes change nothing.
		write_reg(REG_RATIO, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(3'd7, 16'h0000);
		send_sample(24'sh7FFFFF);
		send_sample(-24'sh7FFFFF);
		drain();
		write_reg(REG_RATIO, 16'd100);
		send_sample(24'sh7FFFFF);
		drain();

		// Random phases with varied settings and idling.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			if (ph == 6) begin
				write_all(-16'sd24576, 16'd16384, 16'd12288, 16'd65535, 16'd0);
			end else if (ph == 7) begin
				write_all(16'd0, 16'd256, 16'd0, 16'd0, 16'd65535);
			end else begin
				write_all(($urandom_range(0, 9) == 0) ? 16'($urandom())
						: -16'($urandom_range(0, 24576)),
					($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 32767))
						: 16'($urandom_range(256, 16384)),
					16'($urandom_range(0, 12288)),
					16'($urandom()), 16'($urandom()));
			end
			write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom()));
			for (int n = 0; n < 60; n++) begin
				// Loud bursts followed by quiet tails exercise attack and release.
				if ($urandom_range(0, 3) == 0) begin
					burst = $urandom();
					repeat ($urandom_range(2, 8)) send_sample(burst ^ 24'($urandom_range(0, 255)));
					repeat ($urandom_range(2, 8)) send_sample(burst >>> $urandom_range(8, 23));
				end else begin
					send_sample(random_sample());
				end
				if (ph == 1 && n == 30) begin
					drain();
				end
			end
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("PASS soft_knee_peak_compressor_top");
		end else begin
			$display("FAIL soft_knee_peak_compressor_top");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/skpc_pkg.sv
rtl/core/skpc_regs.sv
rtl/core/skpc_dp.sv
rtl/core/skpc_ctrl.sv
rtl/core/soft_knee_peak_compressor_top.sv
rtl/core/skpc_checker.sv
dv/soft_knee_peak_compressor_checker.sv
dv/soft_knee_peak_compressor_top_tb.sv
